>>> hw/rtl/lru_pkg.sv
`timescale 1ns / 1ps

package lru_pkg;

  localparam int PROCS      = 32;
  localparam int PAGES      = 16;
  localparam int PAGE_BYTES = 128;

  localparam int SLOT_W   = $clog2(PROCS);
  localparam int PG_W     = $clog2(PAGES);
  localparam int PB_SHIFT = $clog2(PAGE_BYTES);
  localparam int IDX_W    = PG_W + 1;
  localparam int PC_W     = 11;
  localparam int MASK_W   = 16;

  // stamps never exceed the saturated tick, which stays below 2^30
  localparam int STAMP_W = 30;
  localparam logic [STAMP_W-1:0] TICK_MAX = STAMP_W'(999999999);

  localparam int MEM_DEPTH = PROCS * PAGES;
  localparam int MEM_AW    = SLOT_W + PG_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            fault;
    logic [PG_W-1:0] needed_page;
    logic            evict_valid;
    logic [PG_W-1:0] evict_page;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [MEM_AW-1:0]  waddr;
    logic [STAMP_W-1:0] wdata;
    logic               re;
    logic [MEM_AW-1:0]  raddr;
  } mem_cmd_t;

endpackage

>>> hw/rtl/lru_in_if.sv
`timescale 1ns / 1ps

interface lru_in_if;
  logic                      valid;
  logic                      ready;
  logic [lru_pkg::SLOT_W-1:0] proc_slot;
  logic                      active;
  logic [lru_pkg::PC_W-1:0]   prog_counter;
  logic [lru_pkg::MASK_W-1:0] resident_mask;
  logic                      pagein_refused;

  modport source (
    output valid, proc_slot, active, prog_counter, resident_mask, pagein_refused,
    input  ready
  );

  modport sink (
    input  valid, proc_slot, active, prog_counter, resident_mask, pagein_refused,
    output ready
  );
endinterface

>>> hw/rtl/lru_out_if.sv
`timescale 1ns / 1ps

interface lru_out_if;
  logic                     valid;
  logic                     ready;
  logic                     fault;
  logic [lru_pkg::PG_W-1:0] needed_page;
  logic                     evict_valid;
  logic [lru_pkg::PG_W-1:0] evict_page;

  modport source (
    output valid, fault, needed_page, evict_valid, evict_page,
    input  ready
  );

  modport sink (
    input  valid, fault, needed_page, evict_valid, evict_page,
    output ready
  );
endinterface

>>> hw/rtl/lru_ram.sv
`timescale 1ns / 1ps

module lru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/lru_ctrl.sv
`timescale 1ns / 1ps

module lru_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  lru_in_if.sink                        req,
  output lru_pkg::mem_cmd_t             mem,
  input  logic [lru_pkg::STAMP_W-1:0]   rdata,
  output logic                          res_valid,
  output lru_pkg::res_t                 res,
  input  logic                          res_take
);

  lru_pkg::state_t state, state_next;

  logic [lru_pkg::MEM_AW-1:0]  clr_addr;
  logic [lru_pkg::STAMP_W-1:0] tick;
  logic [lru_pkg::SLOT_W-1:0]  slot_r;
  logic [lru_pkg::MASK_W-1:0]  mask_r;
  logic [lru_pkg::IDX_W-1:0]   idx;
  logic                        rd_vld;
  logic [lru_pkg::PG_W-1:0]    rd_page;
  logic                        found;
  logic [lru_pkg::STAMP_W-1:0] best;
  logic [lru_pkg::PG_W-1:0]    best_page;

  logic                        acc;
  logic [lru_pkg::PG_W-1:0]    page_in;
  logic                        miss_in;
  logic                        hit;
  logic                        last;
  logic                        found_next;
  logic [lru_pkg::STAMP_W-1:0] best_next;
  logic [lru_pkg::PG_W-1:0]    best_page_next;

  assign req.ready = (state == lru_pkg::ST_IDLE);
  assign acc       = req.valid && req.ready;
  assign res_valid = (state == lru_pkg::ST_DONE);

  assign page_in = lru_pkg::PG_W'(req.prog_counter >> lru_pkg::PB_SHIFT);
  assign miss_in = !req.resident_mask[page_in];

  // strict compare keeps the lowest page on equal stamps
  assign hit  = rd_vld && mask_r[rd_page] && (!found || rdata < best);
  assign last = rd_vld && (rd_page == lru_pkg::PG_W'(lru_pkg::PAGES - 1));

  assign found_next     = found || hit;
  assign best_next      = hit ? rdata : best;
  assign best_page_next = hit ? rd_page : best_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lru_pkg::ST_CLEAR;
      clr_addr <= '0;
      tick     <= lru_pkg::STAMP_W'(1);
      rd_vld   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == lru_pkg::ST_SEARCH) && !idx[lru_pkg::PG_W];
      if (state == lru_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (acc && tick < lru_pkg::TICK_MAX) begin
        tick <= tick + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      slot_r          <= req.proc_slot;
      mask_r          <= req.resident_mask;
      idx             <= '0;
      found           <= 1'b0;
      best            <= '0;
      best_page       <= '0;
      res.fault       <= req.active && miss_in;
      res.needed_page <= req.active ? page_in : '0;
      res.evict_valid <= 1'b0;
      res.evict_page  <= '0;
    end
    if (state == lru_pkg::ST_SEARCH) begin
      idx       <= idx + 1'b1;
      rd_page   <= idx[lru_pkg::PG_W-1:0];
      found     <= found_next;
      best      <= best_next;
      best_page <= best_page_next;
      if (last) begin
        res.evict_valid <= found_next;
        res.evict_page  <= best_page_next;
      end
    end
  end

  always_comb begin
    state_next = state;
    mem        = '0;
    unique case (state)
      lru_pkg::ST_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = clr_addr;
        if (&clr_addr) begin
          state_next = lru_pkg::ST_IDLE;
        end
      end
      lru_pkg::ST_IDLE: begin
        if (req.valid) begin
          mem.we    = req.active;
          mem.waddr = {req.proc_slot, page_in};
          mem.wdata = tick;
          if (req.active && miss_in && req.pagein_refused) begin
            state_next = lru_pkg::ST_SEARCH;
          end else begin
            state_next = lru_pkg::ST_DONE;
          end
        end
      end
      lru_pkg::ST_SEARCH: begin
        mem.re    = !idx[lru_pkg::PG_W];
        mem.raddr = {slot_r, idx[lru_pkg::PG_W-1:0]};
        if (last) begin
          state_next = lru_pkg::ST_DONE;
        end
      end
      lru_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = lru_pkg::ST_IDLE;
        end
      end
      default: state_next = lru_pkg::ST_CLEAR;
    endcase
  end

  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == lru_pkg::ST_SEARCH) |-> !mem.we)
    else $error("stamp write during victim search");

  a_tick_bounded: assert property (@(posedge clk) disable iff (rst)
    tick <= lru_pkg::TICK_MAX)
    else $error("tick past saturation");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state == lru_pkg::ST_SEARCH || state == lru_pkg::ST_DONE))
    else $error("accepted item did not start work");

  a_evict_needs_fault: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.evict_valid) |-> res.fault)
    else $error("victim reported without a fault");

endmodule

>>> hw/rtl/lru_page_replacement.sv
`timescale 1ns / 1ps
// path: accept, DONE state, output register; a refused page-in on a fault
//   adds a search over the slot's PAGES stamps (one stamp read per cycle)
// flow: a new item is accepted only once the previous result has left DONE
// reset: a clearing pass writes zero to all PROCS * PAGES stamps, during
//   which no item is accepted; the tick restarts at one

module lru_page_replacement (
  input  logic       clk,
  input  logic       rst,
  lru_in_if.sink     req,
  lru_out_if.source  rsp
);

  lru_pkg::mem_cmd_t           mem;
  logic [lru_pkg::STAMP_W-1:0] rdata;
  logic                        res_valid;
  lru_pkg::res_t               res;
  logic                        res_take;
  logic                        out_valid;
  lru_pkg::res_t               out_res;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .mem       (mem),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  lru_ram #(
    .WIDTH (lru_pkg::STAMP_W),
    .DEPTH (lru_pkg::MEM_DEPTH)
  ) u_stamps (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  // output register lets the next item in while a result waits
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.fault       = out_res.fault;
  assign rsp.needed_page = out_res.needed_page;
  assign rsp.evict_valid = out_res.evict_valid;
  assign rsp.evict_page  = out_res.evict_page;

  a_victim_not_needed: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.evict_valid) |-> (rsp.evict_page != rsp.needed_page))
    else $error("victim equals the faulting page");

endmodule
